@@ rtl/core/tbpe_pkg.sv @@
// Shared types and constants for the TAP block pulse encoder.
package tbpe_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PILOT_LEN   = 3'd0,
    REG_HDR_COUNT   = 3'd1,
    REG_DAT_COUNT   = 3'd2,
    REG_SYNC_FIRST  = 3'd3,
    REG_SYNC_SECOND = 3'd4,
    REG_ZERO_LEN    = 3'd5,
    REG_ONE_LEN     = 3'd6,
    REG_PAUSE_MS    = 3'd7
  } reg_idx_t;

  // Configuration reset values.
  localparam logic [VAL_W-1:0] RST_PILOT_LEN   = 16'd2168;
  localparam logic [VAL_W-1:0] RST_HDR_COUNT   = 16'd8063;
  localparam logic [VAL_W-1:0] RST_DAT_COUNT   = 16'd3223;
  localparam logic [VAL_W-1:0] RST_SYNC_FIRST  = 16'd667;
  localparam logic [VAL_W-1:0] RST_SYNC_SECOND = 16'd735;
  localparam logic [VAL_W-1:0] RST_ZERO_LEN    = 16'd855;
  localparam logic [VAL_W-1:0] RST_ONE_LEN     = 16'd1710;
  localparam logic [VAL_W-1:0] RST_PAUSE_MS    = 16'd1000;

  // Result entry kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_PILOT = 3'd0,
    KIND_SYNC  = 3'd1,
    KIND_BIT   = 3'd2,
    KIND_PAUSE = 3'd3,
    KIND_ERROR = 3'd4
  } pulse_kind_t;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_LEN_LO = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_DATA   = 2'd2,
    PH_HALT   = 2'd3
  } parse_phase_t;

  // Sequencer steps for one data byte.
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_PILOT    = 5'd0;
  localparam logic [STEP_W-1:0] STEP_SYNC1    = 5'd1;
  localparam logic [STEP_W-1:0] STEP_SYNC2    = 5'd2;
  localparam logic [STEP_W-1:0] STEP_BIT_FIRST = 5'd3;
  localparam logic [STEP_W-1:0] STEP_BIT_LAST = 5'd18;
  localparam logic [STEP_W-1:0] STEP_PAUSE    = 5'd19;

  // Work item passed from the parser to the pulse sequencer.
  typedef struct packed {
    logic              err;    // zero block length
    logic              first;  // flag byte of a block
    logic              last;   // final byte of a block
    logic [BYTE_W-1:0] data;
  } cmd_t;

endpackage

@@ rtl/core/tbpe_front.sv @@
// Byte parser: tracks block lengths and turns bytes into sequencer commands.
module tbpe_front
  import tbpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] tap_byte,
  input  logic              start_of_file,
  output logic              cmd_push,
  output cmd_t              cmd
);

  parse_phase_t      phase_r, phase_nxt;
  logic [BYTE_W-1:0] len_low_r, len_low_nxt;
  logic [VAL_W-1:0]  remain_r, remain_nxt;
  logic              at_start_r, at_start_nxt;

  parse_phase_t      phase_cur;
  logic [VAL_W-1:0]  len_full;
  logic [VAL_W-1:0]  remain_dec;
  logic              produce;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEN_LO;
      len_low_r  <= '0;
      remain_r   <= '0;
      at_start_r <= 1'b1;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      len_low_r  <= len_low_nxt;
      remain_r   <= remain_nxt;
      at_start_r <= at_start_nxt;
    end
  end

  // Parse one byte. A start of file forces the length low byte phase.
  always_comb begin
    phase_cur    = start_of_file ? PH_LEN_LO : phase_r;
    phase_nxt    = phase_cur;
    len_low_nxt  = len_low_r;
    remain_nxt   = remain_r;
    at_start_nxt = at_start_r;
    len_full     = {tap_byte, len_low_r};
    remain_dec   = remain_r - 16'd1;
    produce      = 1'b0;
    cmd.err      = 1'b0;
    cmd.first    = at_start_r;
    cmd.last     = 1'b0;
    cmd.data     = tap_byte;
    unique case (phase_cur)
      PH_LEN_LO: begin
        len_low_nxt = tap_byte;
        phase_nxt   = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        remain_nxt = len_full;
        if (len_full == '0) begin
          produce   = 1'b1;
          cmd.err   = 1'b1;
          phase_nxt = PH_HALT;
        end else begin
          at_start_nxt = 1'b1;
          phase_nxt    = PH_DATA;
        end
      end
      PH_DATA: begin
        produce    = 1'b1;
        remain_nxt = remain_dec;
        cmd.last   = (remain_dec == '0);
        if (remain_dec == '0) begin
          at_start_nxt = 1'b1;
          phase_nxt    = PH_LEN_LO;
        end else begin
          at_start_nxt = 1'b0;
        end
      end
      PH_HALT: begin
        phase_nxt = PH_HALT;
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase
  end

  assign cmd_push = accept && produce;

endmodule

@@ rtl/core/tbpe_cmd_queue.sv @@
// Small command queue between the parser and the pulse sequencer.
module tbpe_cmd_queue
  import tbpe_pkg::*;
#(
  parameter int unsigned DEPTH = 4
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty,
  output logic full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == DEPTH_C);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slot_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/tbpe_back.sv @@
// Pulse sequencer: holds the timing registers and expands commands into entries.
module tbpe_back
  import tbpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [VAL_W-1:0]     cfg_wdata,
  input  cmd_t                 head_cmd,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic [KIND_W-1:0]    out_pulse_kind,
  output logic [VAL_W-1:0]     out_pulse_duration,
  output logic [VAL_W-1:0]     out_repeat_count,
  output logic                 out_mic_level,
  output logic                 out_last_of_run
);

  logic [VAL_W-1:0] pilot_len_r, hdr_cnt_r, dat_cnt_r, sync1_r, sync2_r;
  logic [VAL_W-1:0] zero_len_r, one_len_r, pause_r;

  cmd_t              cur_r;
  logic              cur_valid_r;
  logic [STEP_W-1:0] step_r, step_nxt, start_step;
  logic              mic_r;

  logic              out_valid_r;
  pulse_kind_t       out_kind_r;
  logic [VAL_W-1:0]  out_dur_r, out_rep_r;
  logic              out_mic_r, out_last_r;

  logic              sync1_ok, sync2_ok, pause_ok, head_pilot_ok;
  logic [VAL_W-1:0]  cur_pilot_cnt, head_pilot_cnt;
  logic [3:0]        half_idx;
  logic              bit_val;
  logic              out_free, emit, final_entry, load;

  pulse_kind_t       e_kind;
  logic [VAL_W-1:0]  e_dur, e_rep;
  logic              e_mic;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pilot_len_r <= RST_PILOT_LEN;
      hdr_cnt_r   <= RST_HDR_COUNT;
      dat_cnt_r   <= RST_DAT_COUNT;
      sync1_r     <= RST_SYNC_FIRST;
      sync2_r     <= RST_SYNC_SECOND;
      zero_len_r  <= RST_ZERO_LEN;
      one_len_r   <= RST_ONE_LEN;
      pause_r     <= RST_PAUSE_MS;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_PILOT_LEN:   pilot_len_r <= cfg_wdata;
        REG_HDR_COUNT:   hdr_cnt_r   <= cfg_wdata;
        REG_DAT_COUNT:   dat_cnt_r   <= cfg_wdata;
        REG_SYNC_FIRST:  sync1_r     <= cfg_wdata;
        REG_SYNC_SECOND: sync2_r     <= cfg_wdata;
        REG_ZERO_LEN:    zero_len_r  <= cfg_wdata;
        REG_ONE_LEN:     one_len_r   <= cfg_wdata;
        REG_PAUSE_MS:    pause_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign sync1_ok       = (sync1_r != '0);
  assign sync2_ok       = (sync2_r != '0);
  assign pause_ok       = (pause_r != '0);
  assign cur_pilot_cnt  = (cur_r.data == '0) ? hdr_cnt_r : dat_cnt_r;
  assign head_pilot_cnt = (head_cmd.data == '0) ? hdr_cnt_r : dat_cnt_r;
  assign head_pilot_ok  = (head_pilot_cnt != '0);

  // First step of a new command; steps whose entry is empty are skipped.
  always_comb begin
    if (!head_cmd.first) begin
      start_step = STEP_BIT_FIRST;
    end else if (head_pilot_ok) begin
      start_step = STEP_PILOT;
    end else if (sync1_ok) begin
      start_step = STEP_SYNC1;
    end else if (sync2_ok) begin
      start_step = STEP_SYNC2;
    end else begin
      start_step = STEP_BIT_FIRST;
    end
  end

  // Entry for the current step, the step after it, and whether it ends the run.
  assign half_idx = 4'(step_r - STEP_BIT_FIRST);
  assign bit_val  = cur_r.data[3'd7 - half_idx[3:1]];

  always_comb begin
    e_kind      = KIND_BIT;
    e_dur       = bit_val ? one_len_r : zero_len_r;
    e_rep       = 16'd1;
    e_mic       = ~mic_r;
    final_entry = 1'b0;
    step_nxt    = step_r + 1'b1;
    if (cur_r.err) begin
      e_kind      = KIND_ERROR;
      e_dur       = '0;
      e_rep       = '0;
      e_mic       = mic_r;
      final_entry = 1'b1;
    end else begin
      case (step_r)
        STEP_PILOT: begin
          e_kind   = KIND_PILOT;
          e_dur    = pilot_len_r;
          e_rep    = cur_pilot_cnt;
          e_mic    = mic_r ^ cur_pilot_cnt[0];
          step_nxt = sync1_ok ? STEP_SYNC1 : (sync2_ok ? STEP_SYNC2 : STEP_BIT_FIRST);
        end
        STEP_SYNC1: begin
          e_kind   = KIND_SYNC;
          e_dur    = sync1_r;
          step_nxt = sync2_ok ? STEP_SYNC2 : STEP_BIT_FIRST;
        end
        STEP_SYNC2: begin
          e_kind   = KIND_SYNC;
          e_dur    = sync2_r;
          step_nxt = STEP_BIT_FIRST;
        end
        STEP_BIT_LAST: begin
          final_entry = !(cur_r.last && pause_ok);
          step_nxt    = STEP_PAUSE;
        end
        STEP_PAUSE: begin
          e_kind      = KIND_PAUSE;
          e_dur       = pause_r;
          e_rep       = '0;
          e_mic       = 1'b0;
          final_entry = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake between the sequencer, the queue and the output register.
  assign out_free = !out_valid_r || out_pop;
  assign emit     = cur_valid_r && out_free;
  assign load     = (!cur_valid_r || (emit && final_entry)) && !q_empty;
  assign q_pop    = load;

  // Sequencer state and mic level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      mic_r       <= 1'b0;
    end else begin
      if (emit) begin
        mic_r <= e_mic;
      end
      if (load) begin
        cur_valid_r <= 1'b1;
      end else if (emit && final_entry) begin
        cur_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r  <= head_cmd;
      step_r <= start_step;
    end else if (emit) begin
      step_r <= step_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= e_kind;
      out_dur_r  <= e_dur;
      out_rep_r  <= e_rep;
      out_mic_r  <= e_mic;
      out_last_r <= final_entry;
    end
  end

  assign out_empty          = !out_valid_r;
  assign out_pulse_kind     = out_kind_r;
  assign out_pulse_duration = out_dur_r;
  assign out_repeat_count   = out_rep_r;
  assign out_mic_level      = out_mic_r;
  assign out_last_of_run    = out_last_r;

endmodule

@@ rtl/core/tap_block_pulse_encoder_unit.sv @@
// Top level of the TAP block pulse encoder: parser, command queue and sequencer.
//
//   channel  direction  handshake      payload
//   in_      input      push / full    tap_byte, start_of_file
//   out_     output     pop / empty    pulse_kind, pulse_duration, repeat_count,
//                                      mic_level, last_of_run
//   cfg_     input      we             addr (3 bits), wdata (16 bits)
//
// The parser takes one byte per cycle while the command queue has room.
// The sequencer writes one entry per cycle into the output register while it
// is free; a data byte gives 16 to 20 entries (flag byte and last byte add
// pilot, sync and pause). An output stall holds the sequencer; a long one fills
// the queue and raises in_full. Reset is synchronous; no clearing pass follows.
module tap_block_pulse_encoder_unit
  import tbpe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [BYTE_W-1:0]    in_tap_byte,
  input  logic                 in_start_of_file,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic [KIND_W-1:0]    out_pulse_kind,
  output logic [VAL_W-1:0]     out_pulse_duration,
  output logic [VAL_W-1:0]     out_repeat_count,
  output logic                 out_mic_level,
  output logic                 out_last_of_run,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [VAL_W-1:0]     cfg_wdata
);

  logic q_full, q_empty, q_pop, cmd_push, accept;
  cmd_t push_cmd, head_cmd;

  // An input transfer happens whenever in_push is high and the queue has room.
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  tbpe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .tap_byte      (in_tap_byte),
    .start_of_file (in_start_of_file),
    .cmd_push      (cmd_push),
    .cmd           (push_cmd)
  );

  tbpe_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  tbpe_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .head_cmd           (head_cmd),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_pulse_kind     (out_pulse_kind),
    .out_pulse_duration (out_pulse_duration),
    .out_repeat_count   (out_repeat_count),
    .out_mic_level      (out_mic_level),
    .out_last_of_run    (out_last_of_run)
  );

endmodule

@@ sim/tb_tap_block_pulse_encoder_unit.sv @@
// Self-checking testbench for the TAP block pulse encoder: directed, pressure and random streams.
`timescale 1ns / 1ps

module tb_tap_block_pulse_encoder_unit;
  import tbpe_pkg::*;

  localparam int NUM_REGS     = 8;
  localparam int QUIET_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef logic [VAL_W-1:0] reg_set_t [NUM_REGS];

  // One expected pulse entry.
  typedef struct {
    pulse_kind_t      kind;
    logic [VAL_W-1:0] duration;
    logic [VAL_W-1:0] repeats;
    logic             mic;
    logic             last;
  } pulse_entry_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [BYTE_W-1:0]    in_tap_byte;
  logic                 in_start_of_file;
  logic                 out_pop;
  logic                 out_empty;
  logic [KIND_W-1:0]    out_pulse_kind;
  logic [VAL_W-1:0]     out_pulse_duration;
  logic [VAL_W-1:0]     out_repeat_count;
  logic                 out_mic_level;
  logic                 out_last_of_run;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [VAL_W-1:0]     cfg_wdata;

  // Encoder state mirrored by the testbench.
  reg_set_t          enc_regs;
  parse_phase_t      enc_phase;
  logic [BYTE_W-1:0] enc_len_low;
  logic [VAL_W-1:0]  enc_remaining;
  logic              enc_at_start;
  logic              enc_mic;

  pulse_entry_t pulse_expect_q[$];
  pulse_entry_t pulse_run_q[$];

  int  mismatch_count = 0;
  int  bytes_counted  = 0;
  int  cycle_count    = 0;
  int  pop_hold_left  = 0;
  bit  idle_on        = 1'b1;

  localparam reg_set_t RESET_SET = '{RST_PILOT_LEN, RST_HDR_COUNT, RST_DAT_COUNT,
                                     RST_SYNC_FIRST, RST_SYNC_SECOND, RST_ZERO_LEN,
                                     RST_ONE_LEN, RST_PAUSE_MS};

  tap_block_pulse_encoder_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_tap_byte        (in_tap_byte),
    .in_start_of_file   (in_start_of_file),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_pulse_kind     (out_pulse_kind),
    .out_pulse_duration (out_pulse_duration),
    .out_repeat_count   (out_repeat_count),
    .out_mic_level      (out_mic_level),
    .out_last_of_run    (out_last_of_run),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata)
  );

  // Free-running clock with a 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Appends one entry to the run of the byte being encoded.
  function automatic void note_pulse(pulse_kind_t kind, logic [VAL_W-1:0] dur,
                                     logic [VAL_W-1:0] rep);
    pulse_entry_t e;
    e.kind     = kind;
    e.duration = dur;
    e.repeats  = rep;
    e.mic      = enc_mic;
    e.last     = 1'b0;
    pulse_run_q.push_back(e);
  endfunction

  // Computes the pulse entries that one accepted byte produces.
  task automatic encode_tap_byte(input logic [BYTE_W-1:0] b, input logic sof);
    logic [VAL_W-1:0] cnt;
    logic [VAL_W-1:0] len;
    pulse_run_q.delete();
    if (sof) enc_phase = PH_LEN_LO;
    case (enc_phase)
      PH_LEN_LO: begin
        enc_len_low = b;
        enc_phase   = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        enc_remaining = {b, enc_len_low};
        if (enc_remaining == '0) begin
          note_pulse(KIND_ERROR, '0, '0);
          enc_phase = PH_HALT;
        end else begin
          enc_at_start = 1'b1;
          enc_phase    = PH_DATA;
        end
      end
      PH_DATA: begin
        // The flag byte leads with the pilot tone and the sync pulses.
        if (enc_at_start) begin
          cnt = (b == '0) ? enc_regs[REG_HDR_COUNT] : enc_regs[REG_DAT_COUNT];
          enc_at_start = 1'b0;
          if (cnt != '0) begin
            enc_mic ^= cnt[0];
            note_pulse(KIND_PILOT, enc_regs[REG_PILOT_LEN], cnt);
          end
          if (enc_regs[REG_SYNC_FIRST] != '0) begin
            enc_mic = ~enc_mic;
            note_pulse(KIND_SYNC, enc_regs[REG_SYNC_FIRST], 16'd1);
          end
          if (enc_regs[REG_SYNC_SECOND] != '0) begin
            enc_mic = ~enc_mic;
            note_pulse(KIND_SYNC, enc_regs[REG_SYNC_SECOND], 16'd1);
          end
        end
        // Two half-pulses per bit, most significant bit first.
        for (int k = BYTE_W - 1; k >= 0; k--) begin
          len = b[k] ? enc_regs[REG_ONE_LEN] : enc_regs[REG_ZERO_LEN];
          enc_mic = ~enc_mic;
          note_pulse(KIND_BIT, len, 16'd1);
          enc_mic = ~enc_mic;
          note_pulse(KIND_BIT, len, 16'd1);
        end
        // The last byte of a block closes with the pause.
        enc_remaining = enc_remaining - 16'd1;
        if (enc_remaining == '0) begin
          if (enc_regs[REG_PAUSE_MS] != '0) begin
            enc_mic = 1'b0;
            note_pulse(KIND_PAUSE, enc_regs[REG_PAUSE_MS], '0);
          end
          enc_at_start = 1'b1;
          enc_phase    = PH_LEN_LO;
        end
      end
      default: begin
      end
    endcase
    if (pulse_run_q.size() > 0) pulse_run_q[pulse_run_q.size() - 1].last = 1'b1;
    foreach (pulse_run_q[i]) pulse_expect_q.push_back(pulse_run_q[i]);
  endtask

  // Offers one byte and waits for its transfer; push stays high for a following byte.
  task automatic send_tap_byte(input logic [BYTE_W-1:0] b, input logic sof);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push          <= 1'b1;
    in_tap_byte      <= b;
    in_start_of_file <= sof;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (!(enc_phase == PH_HALT && !sof)) bytes_counted++;
    encode_tap_byte(b, sof);
  endtask

  // Drops push once a sequence of bytes is done.
  task automatic rest_sender();
    in_push <= 1'b0;
  endtask

  // Waits until every expected entry has arrived and the queue has gone quiet.
  task automatic drain_results();
    rest_sender();
    while (pulse_expect_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Writes all registers, one per cycle, and updates the mirrored copy.
  task automatic write_settings(input reg_set_t vals);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= reg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      enc_regs[i] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  // Register value biased toward the extremes and small counts.
  function automatic logic [VAL_W-1:0] pick_reg_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return VAL_W'($urandom_range(1, 5));
    return VAL_W'($urandom);
  endfunction

  // Sends one well-formed block: length, flag byte, then random data.
  task automatic send_tap_block(input int len, input logic [BYTE_W-1:0] flag);
    logic sof;
    sof = (enc_phase != PH_LEN_LO) ? 1'b1 : 1'($urandom_range(0, 1));
    send_tap_byte(BYTE_W'(len), sof);
    send_tap_byte(BYTE_W'(len >> 8), 1'b0);
    send_tap_byte(flag, 1'b0);
    for (int i = 1; i < len; i++) send_tap_byte(BYTE_W'($urandom), 1'b0);
  endtask

  // Mostly well-formed blocks, with truncated blocks, zero lengths and noise.
  task automatic run_random_stream(input int n_bytes);
    int start;
    int r;
    int len;
    int cnt;
    logic [BYTE_W-1:0] flag;
    start = bytes_counted;
    while (bytes_counted - start < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        len  = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 24);
        flag = ($urandom_range(0, 4) < 2) ? '0 : BYTE_W'($urandom);
        send_tap_block(len, flag);
      end else if (r < 85) begin
        // Block cut short; the next block restarts the file.
        send_tap_byte(BYTE_W'($urandom), 1'b1);
        send_tap_byte(BYTE_W'($urandom), 1'b0);
        cnt = $urandom_range(0, 5);
        repeat (cnt) send_tap_byte(BYTE_W'($urandom), 1'b0);
      end else if (r < 92) begin
        // Zero length halts the parser; the bytes after it are dropped unless they restart the file.
        send_tap_byte('0, 1'b1);
        send_tap_byte('0, 1'b0);
        cnt = $urandom_range(0, 3);
        repeat (cnt) send_tap_byte(BYTE_W'($urandom), 1'($urandom_range(0, 4) == 0));
      end else begin
        cnt = $urandom_range(1, 6);
        repeat (cnt) send_tap_byte(BYTE_W'($urandom), 1'($urandom_range(0, 3) == 0));
      end
    end
  endtask

  // Receiver: long hold-offs on request, random stall bursts otherwise.
  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (pop_hold_left > 0) begin
        pop_hold_left--;
        out_pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Compares each result transfer with the oldest expected entry.
  always @(posedge clk) begin : check_results
    pulse_entry_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pulse_expect_q.size() == 0) begin
        $error("Unexpected result: kind %0d duration %0d repeat %0d",
               out_pulse_kind, out_pulse_duration, out_repeat_count);
        mismatch_count++;
      end else begin
        want = pulse_expect_q.pop_front();
        if (out_pulse_kind !== want.kind) begin
          $error("pulse_kind: expected %0d, actual %0d", want.kind, out_pulse_kind);
          mismatch_count++;
        end
        if (out_pulse_duration !== want.duration) begin
          $error("pulse_duration: expected %0d, actual %0d", want.duration,
                 out_pulse_duration);
          mismatch_count++;
        end
        if (out_repeat_count !== want.repeats) begin
          $error("repeat_count: expected %0d, actual %0d", want.repeats, out_repeat_count);
          mismatch_count++;
        end
        if (out_mic_level !== want.mic) begin
          $error("mic_level: expected %0d, actual %0d", want.mic, out_mic_level);
          mismatch_count++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, actual %0d", want.last, out_last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  // Header block, data block, zero length with halt, and a restart, at reset settings.
  task automatic test_reset_settings();
    send_tap_byte(8'h03, 1'b1);
    send_tap_byte(8'h00, 1'b0);
    send_tap_byte(8'h00, 1'b0);
    send_tap_byte(8'hA5, 1'b0);
    send_tap_byte(8'hFF, 1'b0);
    send_tap_byte(8'h02, 1'b0);
    send_tap_byte(8'h00, 1'b0);
    send_tap_byte(8'hFF, 1'b0);
    send_tap_byte(8'h00, 1'b0);
    send_tap_byte(8'h00, 1'b1);
    send_tap_byte(8'h00, 1'b0);
    send_tap_byte(8'h12, 1'b0);
    send_tap_byte(8'h01, 1'b1);
    send_tap_byte(8'h00, 1'b0);
    send_tap_byte(8'h80, 1'b0);
    drain_results();
  endtask

  // All registers at zero, then all at their maximum.
  task automatic test_register_extremes();
    reg_set_t vals;
    foreach (vals[i]) vals[i] = '0;
    write_settings(vals);
    send_tap_byte(8'h01, 1'b1);
    send_tap_byte(8'h00, 1'b0);
    send_tap_byte(8'h7E, 1'b0);
    drain_results();
    foreach (vals[i]) vals[i] = '1;
    write_settings(vals);
    send_tap_byte(8'h01, 1'b1);
    send_tap_byte(8'h00, 1'b0);
    send_tap_byte(8'h00, 1'b0);
    drain_results();
  endtask

  // Receiver holds off while a block keeps coming, so the input stalls.
  task automatic test_backpressure();
    write_settings(RESET_SET);
    pop_hold_left = 400;
    send_tap_block(12, 8'hFF);
    drain_results();
  endtask

  // Random streams under several register settings.
  task automatic test_random_settings();
    reg_set_t vals;
    for (int round = 0; round < 4; round++) begin
      foreach (vals[i]) vals[i] = pick_reg_value();
      write_settings(vals);
      run_random_stream(90);
      drain_results();
    end
  endtask

  // Closing stretch at reset values with no idling on either side.
  task automatic test_no_idle();
    write_settings(RESET_SET);
    idle_on = 1'b0;
    run_random_stream(70);
    drain_results();
  endtask

  // Reset, then the tests in turn, then the verdict.
  initial begin
    in_push          = 1'b0;
    in_tap_byte      = '0;
    in_start_of_file = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = '0;
    cfg_wdata        = '0;
    rst_n            = 1'b0;
    enc_regs         = RESET_SET;
    enc_phase        = PH_LEN_LO;
    enc_len_low      = '0;
    enc_remaining    = '0;
    enc_at_start     = 1'b1;
    enc_mic          = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_settings();
    test_register_extremes();
    test_backpressure();
    test_random_settings();
    test_no_idle();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tbpe_pkg.sv
rtl/core/tbpe_front.sv
rtl/core/tbpe_cmd_queue.sv
rtl/core/tbpe_back.sv
rtl/core/tap_block_pulse_encoder_unit.sv
sim/tb_tap_block_pulse_encoder_unit.sv
